// ===== rtl/core/rfsw_pkg.sv =====
// ----------------------------------------------------------------------------
// rfsw_pkg: shared types and constants of the remote switch frame transmitter
// Holds the item and result structs, frame layout constants and the symbol
// timing helper that the sequencer uses.
// ----------------------------------------------------------------------------
package rfsw_pkg;

  localparam int FrameBits = 32;
  localparam int PosW      = 6;
  localparam int UnitW     = 5;
  localparam int TickW     = 16;
  localparam int RepW      = 8;
  localparam int SwW       = 3;

  localparam logic [19:0]      PrefixCode     = 20'h76D80;
  localparam logic [3:0]       MidCode        = 4'b1001;
  localparam logic [TickW-1:0] UnitTicksReset = 16'd385;
  localparam logic [UnitW-1:0] LongUnits      = 5'd2;
  localparam logic [UnitW-1:0] ShortUnits     = 5'd1;
  localparam logic [UnitW-1:0] SyncHighUnits  = 5'd1;
  localparam logic [UnitW-1:0] SyncLowUnits   = 5'd17;
  localparam logic [PosW-1:0]  SyncPos        = 6'd32;

  // Command codes of an input item.
  localparam logic CmdTick  = 1'b0;
  localparam logic CmdStart = 1'b1;

  typedef struct packed {
    logic            command;
    logic [SwW-1:0]  switch_number;
    logic            turn_on;
    logic [RepW-1:0] repeat_count;
  } item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
  } result_t;

  // Frame as sent, first bit in the MSB.
  function automatic logic [FrameBits-1:0] build_frame(logic [SwW-1:0] sw, logic on);
    return {PrefixCode, sw, on, MidCode, sw, ~on};
  endfunction

  // Length in units of the high or low phase of the symbol at pos.
  function automatic logic [UnitW-1:0] phase_units(logic [FrameBits-1:0] frame,
                                                   logic [PosW-1:0] pos,
                                                   logic low);
    logic one;
    one = frame[~pos[4:0]];
    if (pos >= SyncPos) begin
      return low ? SyncLowUnits : SyncHighUnits;
    end
    return (one ^ low) ? LongUnits : ShortUnits;
  endfunction

endpackage

// ===== rtl/core/rfsw_if.sv =====
// ----------------------------------------------------------------------------
// rfsw_if: channel interfaces of the remote switch frame transmitter
// One interface for the command items and one for the result items, each
// with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rfsw_item_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [rfsw_pkg::SwW-1:0]  switch_number;
  logic                      turn_on;
  logic [rfsw_pkg::RepW-1:0] repeat_count;

  modport source (output valid, command, switch_number, turn_on, repeat_count,
                  input ready);
  modport sink (input valid, command, switch_number, turn_on, repeat_count,
                output ready);
endinterface

interface rfsw_result_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic accepted;

  modport source (output valid, line_level, busy_res, accepted, input ready);
  modport sink (input valid, line_level, busy_res, accepted, output ready);
endinterface

// ===== rtl/core/rfsw_in_reg.sv =====
// ----------------------------------------------------------------------------
// rfsw_in_reg: input register
// Captures one command item per transfer and holds it until the sequencer
// consumes it.
// ----------------------------------------------------------------------------
module rfsw_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  rfsw_item_if.sink       item_i,
  input  logic            adv_i,
  output logic            valid_o,
  output rfsw_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  rfsw_pkg::item_t item_q;
  logic            load;

  assign item_i.ready = !valid_q || adv_i;
  assign load         = item_i.valid && item_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= '{command:       item_i.command,
                  switch_number: item_i.switch_number,
                  turn_on:       item_i.turn_on,
                  repeat_count:  item_i.repeat_count};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/core/rfsw_seq.sv =====
// ----------------------------------------------------------------------------
// rfsw_seq: transmit sequencer
// Holds the frame, repeat, symbol and tick counters, and works out the next
// state and the result of one item in a single pass.
// ----------------------------------------------------------------------------
module rfsw_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  rfsw_pkg::item_t            item_i,
  input  logic [rfsw_pkg::TickW-1:0] unit_ticks_i,
  output rfsw_pkg::result_t          res_o
);

  logic [rfsw_pkg::FrameBits-1:0] frame_q, frame_d;
  logic [rfsw_pkg::RepW-1:0]      reps_q, reps_d;
  logic [rfsw_pkg::PosW-1:0]      pos_q, pos_d;
  logic                           low_q, low_d;
  logic [rfsw_pkg::UnitW-1:0]     units_q, units_d;
  logic [rfsw_pkg::TickW-1:0]     ticks_q, ticks_d;
  logic                           active_q, active_d;

  logic [rfsw_pkg::FrameBits-1:0] new_frame;
  logic [rfsw_pkg::TickW-1:0]     unit_len;
  logic [rfsw_pkg::TickW-1:0]     tick_dec;
  logic [rfsw_pkg::UnitW-1:0]     unit_dec;
  logic [rfsw_pkg::PosW-1:0]      pos_inc;
  logic [rfsw_pkg::RepW-1:0]      rep_dec;
  logic                           taken;

  assign new_frame = rfsw_pkg::build_frame(item_i.switch_number, item_i.turn_on);
  // A unit length of zero counts as one tick.
  assign unit_len  = (unit_ticks_i == '0) ? rfsw_pkg::TickW'(1) : unit_ticks_i;
  assign tick_dec  = ticks_q - rfsw_pkg::TickW'(1);
  assign unit_dec  = units_q - rfsw_pkg::UnitW'(1);
  assign pos_inc   = pos_q + rfsw_pkg::PosW'(1);
  assign rep_dec   = reps_q - rfsw_pkg::RepW'(1);

  always_comb begin
    frame_d  = frame_q;
    reps_d   = reps_q;
    pos_d    = pos_q;
    low_d    = low_q;
    units_d  = units_q;
    ticks_d  = ticks_q;
    active_d = active_q;
    taken    = 1'b0;
    if (item_i.command == rfsw_pkg::CmdStart) begin
      if (!active_q) begin
        taken = 1'b1;
        if (item_i.repeat_count != '0) begin
          frame_d  = new_frame;
          reps_d   = item_i.repeat_count;
          pos_d    = '0;
          active_d = 1'b1;
          low_d    = 1'b0;
          units_d  = rfsw_pkg::phase_units(new_frame, '0, 1'b0);
          ticks_d  = unit_len;
        end
      end
    end else if (active_q) begin
      if (tick_dec != '0) begin
        ticks_d = tick_dec;
      end else begin
        ticks_d = unit_len;
        units_d = unit_dec;
        if (unit_dec == '0) begin
          if (!low_q) begin
            low_d   = 1'b1;
            units_d = rfsw_pkg::phase_units(frame_q, pos_q, 1'b1);
          end else if (pos_q >= rfsw_pkg::SyncPos) begin
            // End of the sync symbol closes one frame.
            reps_d = rep_dec;
            low_d  = 1'b0;
            pos_d  = '0;
            if (rep_dec == '0) begin
              active_d = 1'b0;
              units_d  = '0;
              ticks_d  = '0;
            end else begin
              units_d = rfsw_pkg::phase_units(frame_q, '0, 1'b0);
            end
          end else begin
            pos_d   = pos_inc;
            low_d   = 1'b0;
            units_d = rfsw_pkg::phase_units(frame_q, pos_inc, 1'b0);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q  <= '0;
      reps_q   <= '0;
      pos_q    <= '0;
      low_q    <= 1'b0;
      units_q  <= '0;
      ticks_q  <= '0;
      active_q <= 1'b0;
    end else if (adv_i) begin
      frame_q  <= frame_d;
      reps_q   <= reps_d;
      pos_q    <= pos_d;
      low_q    <= low_d;
      units_q  <= units_d;
      ticks_q  <= ticks_d;
      active_q <= active_d;
    end
  end

  assign res_o = '{line_level: active_d && !low_d,
                   busy_res:   active_d,
                   accepted:   taken};

endmodule

// ===== rtl/core/rfsw_out_reg.sv =====
// ----------------------------------------------------------------------------
// rfsw_out_reg: result register
// Holds one result until the receiver takes it, and reports whether it can
// load a new one in this cycle.
// ----------------------------------------------------------------------------
module rfsw_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rfsw_pkg::result_t res_i,
  output logic              free_o,
  rfsw_result_if.source     result_o
);

  logic              valid_q, valid_d;
  rfsw_pkg::result_t res_q;

  assign free_o = !valid_q || result_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (result_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign result_o.valid      = valid_q;
  assign result_o.line_level = res_q.line_level;
  assign result_o.busy_res   = res_q.busy_res;
  assign result_o.accepted   = res_q.accepted;

endmodule

// ===== rtl/core/rf_switch_frame_transmitter_unit.sv =====
// ----------------------------------------------------------------------------
// rf_switch_frame_transmitter_unit: pulse-width keyed remote switch sender
// Top level of the frame transmitter: input register, sequencer, result
// register and the unit length register.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on item_i is either a time tick or a start command carrying
// the switch number, the on/off flag and the repeat count. A start builds a
// 32-bit frame and keys it out, frame bit by frame bit and then a sync
// symbol, for the requested number of frames. Each tick lets one time tick
// pass. A start while a transmission runs is refused and leaves it alone.
// Every item yields exactly one transfer on result_o: the data line level
// after the item, the busy flag and whether a start was taken.
// The item is captured in the input register at its transfer; the sequencer
// then updates its state and loads the result register when the result
// register has room, and the result can then be taken from result_o.
// Barring a receiver stall, one item is taken in every cycle, since the whole
// state update is one short pass of decrement-and-compare logic between the
// two registers. When the receiver stalls, the result register holds its
// result and the input register holds one more item; item_i.ready then drops.
// Reset empties both registers, sets the line low and idle and loads the unit
// length of 385 ticks. The user writes unit_ticks_i with unit_ticks_we_i only
// while no transfer is in flight, not enforced by the block. While sending,
// a new length applies from the next unit boundary; zero counts as one tick.
// ----------------------------------------------------------------------------
module rf_switch_frame_transmitter_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       unit_ticks_we_i,
  input  logic [rfsw_pkg::TickW-1:0] unit_ticks_i,
  rfsw_item_if.sink                  item_i,
  rfsw_result_if.source              result_o
);

  logic                       in_valid;
  rfsw_pkg::item_t            in_item;
  logic                       out_free;
  logic                       adv;
  rfsw_pkg::result_t          res;
  logic [rfsw_pkg::TickW-1:0] unit_ticks_q;

  // The held item moves on whenever the result register has room.
  assign adv = in_valid && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ticks_q <= rfsw_pkg::UnitTicksReset;
    end else if (unit_ticks_we_i) begin
      unit_ticks_q <= unit_ticks_i;
    end
  end

  rfsw_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .adv_i   (adv),
    .valid_o (in_valid),
    .item_o  (in_item)
  );

  rfsw_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .item_i       (in_item),
    .unit_ticks_i (unit_ticks_q),
    .res_o        (res)
  );

  rfsw_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (adv),
    .res_i    (res),
    .free_o   (out_free),
    .result_o (result_o)
  );

endmodule

// ===== rtl/core/rfsw_checker.sv =====
// ----------------------------------------------------------------------------
// rfsw_checker: port-level checks of the frame transmitter
// Watches the top level's channels and flags broken flow control or
// inconsistent results.
// ----------------------------------------------------------------------------
module rfsw_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic line_level_i,
  input logic busy_res_i,
  input logic accepted_i
);

  // A receiver that takes results never holds up the command side.
  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("item channel stalled while results are taken");

  // The line can only be high during a transmission.
  a_line_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && line_level_i) |-> busy_res_i)
    else $error("line high while idle");

  // A result cannot appear without an earlier item transfer.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i && !(in_valid_i && in_ready_i)) |=> !out_valid_i || in_ready_i)
    else $error("result produced from nothing");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(line_level_i) && $stable(busy_res_i) &&
       $stable(accepted_i)))
    else $error("stalled result changed");

endmodule

bind rf_switch_frame_transmitter_unit rfsw_checker u_rfsw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (item_i.valid),
  .in_ready_i   (item_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .line_level_i (result_o.line_level),
  .busy_res_i   (result_o.busy_res),
  .accepted_i   (result_o.accepted)
);
